@@ rtl/amlh_pkg.sv @@
// shared types, register indexes and constants of the altitude health block
`timescale 1ns / 1ps
package amlh_pkg;

  localparam int WIN_DEPTH = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  CNT_MAX  = 8'd255;
  localparam logic [16:0] GAIN_ONE = 17'd65536;

  // register indexes on the config port
  localparam logic [2:0] REG_READ_FAIL_LIMIT = 3'd0;
  localparam logic [2:0] REG_STALE_LIMIT     = 3'd1;
  localparam logic [2:0] REG_BAD_RUN_LIMIT   = 3'd2;
  localparam logic [2:0] REG_BAD_TOTAL_LIMIT = 3'd3;
  localparam logic [2:0] REG_MIN_ALTITUDE    = 3'd4;
  localparam logic [2:0] REG_MAX_ALTITUDE    = 3'd5;
  localparam logic [2:0] REG_SMOOTHING_GAIN  = 3'd6;

  // sticky fault flags
  localparam logic [2:0] FAULT_READ  = 3'b001;
  localparam logic [2:0] FAULT_STALE = 3'b010;
  localparam logic [2:0] FAULT_BAD   = 3'b100;

  typedef enum logic [1:0] {
    EV_READ_FAIL,
    EV_BAD,
    EV_GOOD
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic [31:0]        now_ms;
    logic [31:0]        sample_ms;
    logic signed [31:0] altitude_mm;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]         read_fail_limit;
    logic [31:0]        stale_limit_ms;
    logic [7:0]         bad_run_limit;
    logic [7:0]         bad_total_limit;
    logic signed [31:0] min_altitude_mm;
    logic signed [31:0] max_altitude_mm;
    logic [16:0]        smoothing_gain;
  } cfg_t;

endpackage

@@ rtl/amlh_if.sv @@
// valid/ready channels for sensor events and health reports
`timescale 1ns / 1ps
interface amlh_evt_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        now_ms;
  logic [31:0]        sample_ms;
  logic               pressure_ok;
  logic signed [31:0] raw_altitude_mm;

  modport source (output valid, action, now_ms, sample_ms, pressure_ok, raw_altitude_mm,
                  input ready);
  modport sink (input valid, action, now_ms, sample_ms, pressure_ok, raw_altitude_mm,
                output ready);
endinterface

interface amlh_result_if;
  logic               valid;
  logic               ready;
  logic               reading_valid;
  logic               fault_any;
  logic [2:0]         fault_bits;
  logic [7:0]         read_fail_run;
  logic [7:0]         bad_run;
  logic [7:0]         bad_total;
  logic signed [31:0] filtered_altitude_mm;
  logic [31:0]        last_update_ms;

  modport source (output valid, reading_valid, fault_any, fault_bits, read_fail_run,
                  bad_run, bad_total, filtered_altitude_mm, last_update_ms,
                  input ready);
  modport sink (input valid, reading_valid, fault_any, fault_bits, read_fail_run,
                bad_run, bad_total, filtered_altitude_mm, last_update_ms,
                output ready);
endinterface

@@ rtl/amlh_cfg.sv @@
// configuration register file of the altitude health block
`timescale 1ns / 1ps
module amlh_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output amlh_pkg::cfg_t cfg
);
  import amlh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_fail_limit <= 8'd3;
      cfg.stale_limit_ms  <= 32'd1000;
      cfg.bad_run_limit   <= 8'd5;
      cfg.bad_total_limit <= 8'd20;
      cfg.min_altitude_mm <= -32'sd100000;
      cfg.max_altitude_mm <= 32'sd10000000;
      cfg.smoothing_gain  <= 17'd16384;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_READ_FAIL_LIMIT: cfg.read_fail_limit <= cfg_data[7:0];
        REG_STALE_LIMIT:     cfg.stale_limit_ms  <= cfg_data;
        REG_BAD_RUN_LIMIT:   cfg.bad_run_limit   <= cfg_data[7:0];
        REG_BAD_TOTAL_LIMIT: cfg.bad_total_limit <= cfg_data[7:0];
        REG_MIN_ALTITUDE:    cfg.min_altitude_mm <= $signed(cfg_data);
        REG_MAX_ALTITUDE:    cfg.max_altitude_mm <= $signed(cfg_data);
        REG_SMOOTHING_GAIN:  cfg.smoothing_gain  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/amlh_front.sv @@
// front end: takes sensor events and sorts them into read failure, bad or good
`timescale 1ns / 1ps
module amlh_front (
  input  amlh_pkg::cfg_t    cfg,
  amlh_evt_if.sink          evt,
  input  logic              q_full,
  output logic              push,
  output amlh_pkg::q_entry_t push_entry
);
  import amlh_pkg::*;

  logic out_of_range;

  assign out_of_range = (evt.raw_altitude_mm < cfg.min_altitude_mm) ||
                        (evt.raw_altitude_mm > cfg.max_altitude_mm);

  assign evt.ready = !q_full;
  assign push      = evt.valid && !q_full;

  always_comb begin
    if (!evt.action) begin
      push_entry.kind = EV_READ_FAIL;
    end else if (!evt.pressure_ok || out_of_range) begin
      push_entry.kind = EV_BAD;
    end else begin
      push_entry.kind = EV_GOOD;
    end
    push_entry.now_ms      = evt.now_ms;
    push_entry.sample_ms   = evt.sample_ms;
    push_entry.altitude_mm = evt.raw_altitude_mm;
  end

endmodule

@@ rtl/amlh_queue.sv @@
// two-entry queue of classified events between front and back
`timescale 1ns / 1ps
module amlh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  amlh_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output amlh_pkg::q_entry_t head_entry
);
  import amlh_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty  = (count != '0);
  assign head_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/amlh_back.sv @@
// back end: counters, faults, median window and low pass, held as the report word
`timescale 1ns / 1ps
module amlh_back (
  input  logic               clk,
  input  logic               rst,
  input  amlh_pkg::cfg_t     cfg,
  input  logic               q_not_empty,
  input  amlh_pkg::q_entry_t head_entry,
  output logic               pop,
  amlh_result_if.source      result
);
  import amlh_pkg::*;

  logic signed [31:0] win [WIN_DEPTH];
  logic [1:0]         win_head;
  logic [1:0]         win_fill;
  logic               smoother_ready;
  logic signed [31:0] smoothed;
  logic [7:0]         fail_run;
  logic [7:0]         bad_run;
  logic [7:0]         bad_total;
  logic [31:0]        last_good_ms;
  logic               has_good;
  logic               sticky;
  logic [2:0]         sticky_bits;
  logic               valid_flag;
  logic [31:0]        published_ms;
  logic               out_valid;

  logic [1:0]         win_head_next;
  logic [1:0]         win_fill_next;
  logic               smoother_ready_next;
  logic signed [31:0] smoothed_next;
  logic [7:0]         fail_run_next;
  logic [7:0]         bad_run_next;
  logic [7:0]         bad_total_next;
  logic [31:0]        last_good_ms_next;
  logic               has_good_next;
  logic               sticky_next;
  logic [2:0]         sticky_bits_next;
  logic               valid_flag_next;
  logic [31:0]        published_ms_next;

  logic signed [31:0] w [WIN_DEPTH];
  logic [1:0]         fill_after;
  logic signed [31:0] lo01;
  logic signed [31:0] hi01;
  logic signed [31:0] mid;
  logic signed [31:0] median;
  logic [16:0]        gain;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [34:0] ema_sum;
  logic [31:0]        elapsed;
  logic [2:0]         raise_bits;

  // next word may enter once the report slot is free or being taken
  assign pop = q_not_empty && (!out_valid || result.ready);

  // window contents as they stand once the new altitude is written
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w[i] = (win_head == 2'(i)) ? head_entry.altitude_mm : win[i];
    end
  end

  assign fill_after = (win_fill == 2'(WIN_DEPTH)) ? win_fill : win_fill + 1'b1;

  assign lo01 = (w[0] < w[1]) ? w[0] : w[1];
  assign hi01 = (w[0] < w[1]) ? w[1] : w[0];
  assign mid  = (hi01 < w[2]) ? hi01 : w[2];

  always_comb begin
    case (fill_after)
      2'd1:    median = w[0];
      2'd2:    median = hi01;
      default: median = (lo01 > mid) ? lo01 : mid;
    endcase
  end

  // floor of gain * difference / 2^16, gain clamped at one
  assign gain    = (cfg.smoothing_gain > GAIN_ONE) ? GAIN_ONE : cfg.smoothing_gain;
  assign diff    = {median[31], median} - {smoothed[31], smoothed};
  assign prod    = diff * $signed({1'b0, gain});
  assign ema_sum = {{3{smoothed[31]}}, smoothed} + prod[50:16];

  assign elapsed = head_entry.now_ms - last_good_ms;

  always_comb begin
    win_head_next       = win_head;
    win_fill_next       = win_fill;
    smoother_ready_next = smoother_ready;
    smoothed_next       = smoothed;
    fail_run_next       = fail_run;
    bad_run_next        = bad_run;
    bad_total_next      = bad_total;
    last_good_ms_next   = last_good_ms;
    has_good_next       = has_good;
    sticky_next         = sticky;
    sticky_bits_next    = sticky_bits;
    valid_flag_next     = valid_flag;
    published_ms_next   = published_ms;
    raise_bits          = '0;

    unique case (head_entry.kind)
      EV_READ_FAIL: begin
        fail_run_next = (fail_run == CNT_MAX) ? fail_run : fail_run + 1'b1;
        if (fail_run_next >= cfg.read_fail_limit) begin
          raise_bits = raise_bits | FAULT_READ;
        end
        if (has_good && (elapsed >= cfg.stale_limit_ms)) begin
          raise_bits = raise_bits | FAULT_STALE;
        end
      end
      EV_BAD: begin
        fail_run_next  = '0;
        bad_run_next   = (bad_run == CNT_MAX) ? bad_run : bad_run + 1'b1;
        bad_total_next = (bad_total == CNT_MAX) ? bad_total : bad_total + 1'b1;
        if ((bad_run_next >= cfg.bad_run_limit) || (bad_total_next >= cfg.bad_total_limit))
        begin
          raise_bits = FAULT_BAD;
        end
      end
      EV_GOOD: begin
        fail_run_next       = '0;
        bad_run_next        = '0;
        win_head_next       = (win_head == 2'(WIN_DEPTH - 1)) ? 2'd0 : win_head + 1'b1;
        win_fill_next       = fill_after;
        smoothed_next       = smoother_ready ? ema_sum[31:0] : median;
        smoother_ready_next = 1'b1;
        valid_flag_next     = 1'b1;
        published_ms_next   = head_entry.sample_ms;
        last_good_ms_next   = head_entry.sample_ms;
        has_good_next       = 1'b1;
      end
      default: ;
    endcase

    // any fault empties the window and drops the seed
    if (raise_bits != '0) begin
      sticky_next         = 1'b1;
      sticky_bits_next    = sticky_bits | raise_bits;
      valid_flag_next     = 1'b0;
      win_head_next       = '0;
      win_fill_next       = '0;
      smoother_ready_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head_entry.kind == EV_GOOD)) begin
      win[win_head] <= head_entry.altitude_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_head       <= '0;
      win_fill       <= '0;
      smoother_ready <= 1'b0;
      smoothed       <= '0;
      fail_run       <= '0;
      bad_run        <= '0;
      bad_total      <= '0;
      last_good_ms   <= '0;
      has_good       <= 1'b0;
      sticky         <= 1'b0;
      sticky_bits    <= '0;
      valid_flag     <= 1'b0;
      published_ms   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        win_head       <= win_head_next;
        win_fill       <= win_fill_next;
        smoother_ready <= smoother_ready_next;
        smoothed       <= smoothed_next;
        fail_run       <= fail_run_next;
        bad_run        <= bad_run_next;
        bad_total      <= bad_total_next;
        last_good_ms   <= last_good_ms_next;
        has_good       <= has_good_next;
        sticky         <= sticky_next;
        sticky_bits    <= sticky_bits_next;
        valid_flag     <= valid_flag_next;
        published_ms   <= published_ms_next;
        out_valid      <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid                = out_valid;
  assign result.reading_valid        = valid_flag;
  assign result.fault_any            = sticky;
  assign result.fault_bits           = sticky_bits;
  assign result.read_fail_run        = fail_run;
  assign result.bad_run              = bad_run;
  assign result.bad_total            = bad_total;
  assign result.filtered_altitude_mm = smoothed;
  assign result.last_update_ms       = published_ms;

endmodule

@@ rtl/altitude_median_lowpass_health.sv @@
// altitude health monitor: one sensor event word in, one health report word out.
// each event word is a read failure or a delivered sample; samples are checked
// for pressure and altitude range, good ones go through a three-deep median and
// a first-order low pass (alpha in q1.16, rounding towards minus infinity), and
// read failures, bad values and staleness raise sticky faults that clear the
// window and the low pass seed. throughput is one word per clock while reports
// are taken: the front end classifies and writes a two-word queue, the back end
// takes one queued word a cycle and updates all state, median and filter in that
// single cycle, and the report word is held in the back end's state registers
// until taken. an event is registered in the queue, then in those registers; a
// stalled report side fills the queue after two more words; then events stall.
// the user must write config only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
module altitude_median_lowpass_health (
  input  logic        clk,
  input  logic        rst,
  // config write port, no read-back
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // event words in, report words out
  amlh_evt_if.sink      evt,
  amlh_result_if.source result
);
  import amlh_pkg::*;

  cfg_t     cfg;
  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_not_empty;
  q_entry_t head_entry;
  logic     pop;

  // limits, range and gain registers
  amlh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // range check and event sorting
  amlh_front u_front (
    .cfg        (cfg),
    .evt        (evt),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the event side from a stalled report side
  amlh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head_entry (head_entry)
  );

  // counters, faults, median and low pass; drives the report word
  amlh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head_entry  (head_entry),
    .pop         (pop),
    .result      (result)
  );

endmodule

@@ tb/altitude_median_lowpass_health_test.sv @@
// self-checking bench for the altitude health block, predicting and comparing every report word
`timescale 1ns / 1ps
module altitude_median_lowpass_health_test;
  import amlh_pkg::*;

  // event word codes on the action field
  localparam logic ACT_READ_FAIL = 1'b0;
  localparam logic ACT_SAMPLE    = 1'b1;

  localparam logic signed [31:0] ALT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ALT_MAX = 32'sh7FFF_FFFF;
  localparam longint S32_MAX = longint'(32'h7FFF_FFFF);
  localparam longint S32_MIN = -longint'(32'h8000_0000);

  localparam int HOLD_CYCLES    = 60;   // long report hold-off in the pressure test
  localparam int SETTLE_CYCLES  = 4;    // settling margin after the last report
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moving on either side
  localparam int PHASE_WORDS    = 230;

  typedef struct {
    logic               action;
    logic [31:0]        now_ms;
    logic [31:0]        sample_ms;
    logic               pressure_ok;
    logic signed [31:0] alt_mm;
  } sensor_word_t;

  typedef struct packed {
    logic               reading_valid;
    logic               fault_any;
    logic [2:0]         fault_bits;
    logic [7:0]         read_fail_run;
    logic [7:0]         bad_run;
    logic [7:0]         bad_total;
    logic signed [31:0] filtered_mm;
    logic [31:0]        update_ms;
  } health_report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  amlh_evt_if    evt_bus ();
  amlh_result_if result_bus ();

  altitude_median_lowpass_health dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_bus),
    .result    (result_bus)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow of the block: its settings and its health state
  // ---------------------------------------------------------------------------
  cfg_t               settings;
  logic signed [31:0] win_mem [WIN_DEPTH];
  logic [1:0]         win_head;
  logic [1:0]         win_fill;
  logic               lp_seeded;
  logic signed [31:0] lp_value;
  logic [7:0]         fail_run;
  logic [7:0]         bad_run_cnt;
  logic [7:0]         bad_total_cnt;
  logic [31:0]        last_good_ms;   // also the published timestamp
  logic               have_good;
  logic               fault_seen;
  logic [2:0]         fault_flags;
  logic               reading_ok;

  health_report_t pending_reports [$];
  int             mismatches;

  // stimulus knobs shared between the sender, the report sink and the tests
  int                 tx_gap_pct;
  int                 rx_stall_pct;
  bit                 hold_request;
  logic [31:0]        ms_clock;
  logic signed [31:0] trend_mm;

  function automatic cfg_t make_settings(logic [7:0] rfl, logic [31:0] stale, logic [7:0] brl,
                                         logic [7:0] btl, logic signed [31:0] lo,
                                         logic signed [31:0] hi, logic [16:0] gain);
    cfg_t s;
    s.read_fail_limit = rfl;
    s.stale_limit_ms  = stale;
    s.bad_run_limit   = brl;
    s.bad_total_limit = btl;
    s.min_altitude_mm = lo;
    s.max_altitude_mm = hi;
    s.smoothing_gain  = gain;
    return s;
  endfunction

  function automatic void reset_shadow();
    settings = make_settings(8'd3, 32'd1000, 8'd5, 8'd20, -32'sd100000, 32'sd10000000,
                             17'd16384);
    foreach (win_mem[i]) win_mem[i] = '0;
    win_head      = '0;
    win_fill      = '0;
    lp_seeded     = 1'b0;
    lp_value      = '0;
    fail_run      = '0;
    bad_run_cnt   = '0;
    bad_total_cnt = '0;
    last_good_ms  = '0;
    have_good     = 1'b0;
    fault_seen    = 1'b0;
    fault_flags   = '0;
    reading_ok    = 1'b0;
  endfunction

  // a fault empties the window and forgets the low pass seed
  function automatic void raise_fault(logic [2:0] flag);
    fault_seen  = 1'b1;
    fault_flags = fault_flags | flag;
    reading_ok  = 1'b0;
    win_head    = '0;
    win_fill    = '0;
    lp_seeded   = 1'b0;
  endfunction

  // median of the filled entries; with two entries the larger one
  function automatic logic signed [31:0] window_median();
    logic signed [31:0] a, b, c, lo_ab, hi_ab, mid;
    a = win_mem[0];
    b = win_mem[1];
    c = win_mem[2];
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    if (win_fill == 2'd1) begin
      return a;
    end else if (win_fill == 2'd2) begin
      return hi_ab;
    end
    mid = (hi_ab < c) ? hi_ab : c;
    return (lo_ab > mid) ? lo_ab : mid;
  endfunction

  // first-order low pass, floor of gain * difference / 65536, gain clamped to one
  function automatic void lowpass_update(logic signed [31:0] m);
    logic [16:0] g;
    longint      diff, prod, next;
    if (!lp_seeded) begin
      lp_value  = m;
      lp_seeded = 1'b1;
      return;
    end
    g    = (settings.smoothing_gain > GAIN_ONE) ? GAIN_ONE : settings.smoothing_gain;
    diff = longint'(m) - longint'(lp_value);
    prod = diff * longint'(g);
    next = longint'(lp_value) + (prod >>> 16);
    if (next > S32_MAX) next = S32_MAX;
    if (next < S32_MIN) next = S32_MIN;
    lp_value = next[31:0];
  endfunction

  function automatic health_report_t advance_health(sensor_word_t w);
    health_report_t     r;
    logic [31:0]        elapsed;
    logic signed [31:0] lo, hi;
    lo = settings.min_altitude_mm;
    hi = settings.max_altitude_mm;
    if (w.action == ACT_READ_FAIL) begin
      if (fail_run != CNT_MAX) fail_run = fail_run + 8'd1;
      if (fail_run >= settings.read_fail_limit) raise_fault(FAULT_READ);
      // stale only counts once a good sample has been seen; time wraps
      elapsed = w.now_ms - last_good_ms;
      if (have_good && elapsed >= settings.stale_limit_ms) raise_fault(FAULT_STALE);
    end else begin
      fail_run = '0;
      if (!w.pressure_ok || w.alt_mm < lo || w.alt_mm > hi) begin
        if (bad_run_cnt != CNT_MAX) bad_run_cnt = bad_run_cnt + 8'd1;
        if (bad_total_cnt != CNT_MAX) bad_total_cnt = bad_total_cnt + 8'd1;
        if (bad_run_cnt >= settings.bad_run_limit || bad_total_cnt >= settings.bad_total_limit)
          raise_fault(FAULT_BAD);
      end else begin
        bad_run_cnt       = '0;
        win_mem[win_head] = w.alt_mm;
        win_head          = (win_head == 2'(WIN_DEPTH - 1)) ? 2'd0 : win_head + 2'd1;
        if (win_fill != 2'(WIN_DEPTH)) win_fill = win_fill + 2'd1;
        lowpass_update(window_median());
        reading_ok   = 1'b1;
        last_good_ms = w.sample_ms;
        have_good    = 1'b1;
      end
    end
    r.reading_valid = reading_ok;
    r.fault_any     = fault_seen;
    r.fault_bits    = fault_flags;
    r.read_fail_run = fail_run;
    r.bad_run       = bad_run_cnt;
    r.bad_total     = bad_total_cnt;
    r.filtered_mm   = lp_value;
    r.update_ms     = last_good_ms;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------
  function automatic sensor_word_t sample_word(logic [31:0] stamp, logic ok,
                                               logic signed [31:0] alt);
    sensor_word_t w;
    w.action      = ACT_SAMPLE;
    w.now_ms      = stamp;
    w.sample_ms   = stamp;
    w.pressure_ok = ok;
    w.alt_mm      = alt;
    return w;
  endfunction

  function automatic sensor_word_t read_fail_word(logic [31:0] stamp);
    sensor_word_t w;
    w.action      = ACT_READ_FAIL;
    w.now_ms      = stamp;
    w.sample_ms   = $urandom;
    w.pressure_ok = 1'($urandom_range(0, 1));
    w.alt_mm      = $urandom;
    return w;
  endfunction

  // mostly good samples walking around a trend, with spikes, read failures,
  // bad values and some pure noise
  function automatic sensor_word_t random_word();
    sensor_word_t       w;
    int                 pick;
    logic [63:0]        r64;
    logic [63:0]        span;
    logic signed [31:0] lo, hi;
    lo = settings.min_altitude_mm;
    hi = settings.max_altitude_mm;
    ms_clock = ms_clock + 32'($urandom_range(1, 400));
    if ($urandom_range(0, 49) == 0) ms_clock = $urandom;
    w.action      = ACT_SAMPLE;
    w.now_ms      = ms_clock;
    w.sample_ms   = ($urandom_range(0, 9) == 0) ? $urandom : ms_clock;
    w.pressure_ok = 1'b1;
    w.alt_mm      = trend_mm;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      trend_mm = trend_mm + 32'($urandom_range(0, 2000)) - 32'd1000;
      if ($urandom_range(0, 19) == 0) begin
        // single spike the median should swallow
        w.alt_mm = trend_mm + 32'($urandom_range(0, 2000000)) - 32'd1000000;
      end else begin
        w.alt_mm = trend_mm;
      end
      if (lo <= hi && (w.alt_mm < lo || w.alt_mm > hi)) begin
        span     = 64'(longint'(hi) - longint'(lo) + 1);
        r64      = {$urandom, $urandom};
        w.alt_mm = lo + 32'(r64 % span);
        trend_mm = w.alt_mm;
      end
    end else if (pick < 80) begin
      w = read_fail_word(ms_clock);
    end else if (pick < 88) begin
      w.pressure_ok = 1'b0;
      w.alt_mm      = $urandom;
    end else if (pick < 95) begin
      // just outside the accepted range
      if ($urandom_range(0, 1) == 1 && lo != ALT_MIN) begin
        w.alt_mm = lo - 32'sd1;
      end else if (hi != ALT_MAX) begin
        w.alt_mm = hi + 32'sd1;
      end else if (lo != ALT_MIN) begin
        w.alt_mm = lo - 32'sd1;
      end else begin
        w.pressure_ok = 1'b0;
        w.alt_mm      = $urandom;
      end
    end else begin
      w.action      = 1'($urandom_range(0, 1));
      w.now_ms      = $urandom;
      w.sample_ms   = $urandom;
      w.pressure_ok = 1'($urandom_range(0, 1));
      w.alt_mm      = $urandom;
    end
    return w;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // event side: one word per call, driven at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input sensor_word_t w);
    int gap;
    @(negedge clk);
    evt_bus.valid           <= 1'b1;
    evt_bus.action          <= w.action;
    evt_bus.now_ms          <= w.now_ms;
    evt_bus.sample_ms       <= w.sample_ms;
    evt_bus.pressure_ok     <= w.pressure_ok;
    evt_bus.raw_altitude_mm <= w.alt_mm;
    do @(posedge clk); while (!evt_bus.ready);
    // word taken at this edge: predict its report now
    pending_reports.push_back(advance_health(w));
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      evt_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering words and wait until every predicted report is back
  task automatic drain_reports();
    @(negedge clk);
    evt_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all seven registers, only ever called with the block idle
  task automatic apply_settings(input cfg_t s);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_READ_FAIL_LIMIT;
    cfg_data  <= 32'(s.read_fail_limit);
    @(negedge clk);
    cfg_index <= REG_STALE_LIMIT;
    cfg_data  <= s.stale_limit_ms;
    @(negedge clk);
    cfg_index <= REG_BAD_RUN_LIMIT;
    cfg_data  <= 32'(s.bad_run_limit);
    @(negedge clk);
    cfg_index <= REG_BAD_TOTAL_LIMIT;
    cfg_data  <= 32'(s.bad_total_limit);
    @(negedge clk);
    cfg_index <= REG_MIN_ALTITUDE;
    cfg_data  <= s.min_altitude_mm;
    @(negedge clk);
    cfg_index <= REG_MAX_ALTITUDE;
    cfg_data  <= s.max_altitude_mm;
    @(negedge clk);
    cfg_index <= REG_SMOOTHING_GAIN;
    cfg_data  <= 32'(s.smoothing_gain);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings = s;
  endtask

  // ---------------------------------------------------------------------------
  // report side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : report_sink
    int stall_left;
    stall_left       = 0;
    result_bus.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // long hold-off, counted here while the sender keeps offering words
        hold_request = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) stall_left = pick_gap();
      end
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // every report word taken is held against the oldest prediction
  always @(posedge clk) begin : report_check
    health_report_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: report word with none expected, expected none actual %0h", $time,
                 result_bus.filtered_altitude_mm);
      end else begin
        want = pending_reports.pop_front();
        check_field("reading_valid", 32'(want.reading_valid), 32'(result_bus.reading_valid));
        check_field("fault_any", 32'(want.fault_any), 32'(result_bus.fault_any));
        check_field("fault_bits", 32'(want.fault_bits), 32'(result_bus.fault_bits));
        check_field("read_fail_run", 32'(want.read_fail_run), 32'(result_bus.read_fail_run));
        check_field("bad_run", 32'(want.bad_run), 32'(result_bus.bad_run));
        check_field("bad_total", 32'(want.bad_total), 32'(result_bus.bad_total));
        check_field("filtered_altitude_mm", want.filtered_mm, result_bus.filtered_altitude_mm);
        check_field("last_update_ms", want.update_ms, result_bus.last_update_ms);
      end
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((evt_bus.valid && evt_bus.ready) || (result_bus.valid && result_bus.ready) || rst)
        quiet = 0;
      else
        quiet = quiet + 1;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: range edges, bad pressure, read fail and stale limits,
  // stale across the wrap of the millisecond clock, bad run limit
  task automatic test_default_settings();
    tx_gap_pct   = 10;
    rx_stall_pct = 10;
    send_word(sample_word(32'd100, 1'b1, 32'sd0));            // seeds the low pass
    send_word(sample_word(32'd200, 1'b1, 32'sd10000000));     // top edge, larger of two
    send_word(sample_word(32'd300, 1'b1, -32'sd100000));      // bottom edge, median of three
    send_word(sample_word(32'd400, 1'b1, 32'sd10000001));     // just above
    send_word(sample_word(32'd500, 1'b1, -32'sd100001));      // just below
    send_word(sample_word(32'd600, 1'b0, 32'sd5000));         // bad pressure
    send_word(read_fail_word(32'd700));
    send_word(sample_word(32'd900, 1'b1, 32'sd1234));         // clears both runs
    send_word(read_fail_word(32'd1899));                      // one short of stale
    send_word(read_fail_word(32'd1900));                      // stale exactly at limit
    send_word(read_fail_word(32'd1950));                      // read fail limit
    send_word(sample_word(32'hFFFF_FF00, 1'b1, 32'sd42));     // reseed near the wrap
    send_word(read_fail_word(32'h0000_02E7));
    send_word(read_fail_word(32'h0000_02E8));                 // stale over the wrap
    send_word(sample_word(32'hFFFF_FFFF, 1'b1, ALT_MAX));
    send_word(sample_word(32'h0000_0000, 1'b1, ALT_MIN));
    send_word(sample_word(32'h5555_AAAA, 1'b0, 32'sd0));
    send_word(sample_word(32'hAAAA_5555, 1'b0, 32'sd0));
    send_word(sample_word(32'h0000_0001, 1'b0, -32'sd1));     // fifth bad in a row
    drain_reports();
  endtask

  // full range with extreme altitudes, gain of one, gain above one, gain of
  // zero, limits of zero and a range with its bounds swapped
  task automatic test_limits_and_extremes();
    apply_settings(make_settings(CNT_MAX, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, ALT_MIN, ALT_MAX,
                                 GAIN_ONE));
    send_word(sample_word(32'd10, 1'b1, ALT_MIN));
    send_word(sample_word(32'd20, 1'b1, ALT_MAX));
    send_word(sample_word(32'd30, 1'b1, ALT_MIN));
    drain_reports();
    apply_settings(make_settings(CNT_MAX, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, ALT_MIN, ALT_MAX,
                                 17'h1FFFF));
    send_word(sample_word(32'd40, 1'b1, 32'sd1000));
    send_word(sample_word(32'd50, 1'b1, -32'sd7));
    drain_reports();
    apply_settings(make_settings(CNT_MAX, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, ALT_MIN, ALT_MAX,
                                 17'd0));
    send_word(sample_word(32'd60, 1'b1, 32'sd777777));        // value must hold
    drain_reports();
    // zero limits: every count meets them at once
    apply_settings(make_settings(8'd0, 32'd0, 8'd0, 8'd0, ALT_MIN, ALT_MAX, 17'd16384));
    send_word(read_fail_word(32'd70));
    send_word(sample_word(32'd80, 1'b1, 32'sd5));
    send_word(sample_word(32'd90, 1'b0, 32'sd5));
    drain_reports();
    // swapped bounds: nothing is in range
    apply_settings(make_settings(8'd3, 32'd1000, 8'd5, CNT_MAX, 32'sd10, -32'sd10,
                                 17'd16384));
    send_word(sample_word(32'd100, 1'b1, 32'sd0));
    send_word(sample_word(32'd110, 1'b1, 32'sd10));
    drain_reports();
  endtask

  // long random streams under a range of settings, idling on both sides in all but one phase
  task automatic test_random_phases();
    cfg_t s;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          s = make_settings(8'd3, 32'd1000, 8'd5, 8'd100, -32'sd100000, 32'sd10000000,
                            17'd16384);
          tx_gap_pct = 20; rx_stall_pct = 20;
        end
        1: begin
          // widest limits and no idling at all
          s = make_settings(CNT_MAX, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, ALT_MIN, ALT_MAX,
                            GAIN_ONE);
          tx_gap_pct = 0; rx_stall_pct = 0;
        end
        2: begin
          s = make_settings(8'd1, 32'd1, 8'd1, CNT_MAX, 32'sd0, 32'sd1000000, 17'd0);
          tx_gap_pct = 30; rx_stall_pct = 30;
        end
        3: begin
          s = make_settings(8'($urandom_range(1, 8)), 32'($urandom_range(200, 3000)),
                            8'($urandom_range(1, 8)), 8'($urandom_range(30, 255)),
                            -32'($urandom_range(0, 1000000)), 32'($urandom_range(0, 20000000)),
                            17'($urandom_range(0, 65536)));
          tx_gap_pct = 20; rx_stall_pct = 40;
        end
        4: begin
          s = make_settings(8'd4, 32'd2000, 8'd6, CNT_MAX, -32'sd5000000, 32'sd5000000,
                            17'h1FFFF);
          tx_gap_pct = 40; rx_stall_pct = 15;
        end
        default: begin
          // random values in every register, bounds may come out swapped
          s = make_settings(8'($urandom_range(1, 255)), $urandom, 8'($urandom_range(1, 255)),
                            8'($urandom_range(1, 255)), $urandom, $urandom,
                            17'($urandom_range(0, 131071)));
          tx_gap_pct = 25; rx_stall_pct = 25;
        end
      endcase
      apply_settings(s);
      repeat (PHASE_WORDS) send_word(random_word());
      drain_reports();
    end
  endtask

  // report side held off long enough to fill the queue and stall the event
  // side, then a pause mid-stream until every report is back
  task automatic test_report_backpressure();
    apply_settings(make_settings(8'd3, 32'd1000, 8'd5, CNT_MAX, ALT_MIN, ALT_MAX, 17'd30000));
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 1'b1;
    repeat (12) send_word(random_word());
    drain_reports();
    tx_gap_pct   = 15;
    rx_stall_pct = 15;
    repeat (8) send_word(random_word());
    drain_reports();
    repeat (8) send_word(random_word());
    drain_reports();
  endtask

  // counters pinned at their ceiling
  task automatic test_counter_saturation();
    apply_settings(make_settings(CNT_MAX, 32'hFFFF_FFFF, CNT_MAX, CNT_MAX, ALT_MIN, ALT_MAX,
                                 17'd8192));
    tx_gap_pct   = 15;
    rx_stall_pct = 15;
    send_word(sample_word(32'd0, 1'b1, 32'sd500));
    repeat (260) send_word(read_fail_word($urandom));
    repeat (260) send_word(sample_word($urandom, 1'b0, $urandom));
    repeat (4) send_word(sample_word($urandom, 1'b1, $urandom));
    drain_reports();
  endtask

  initial begin : main_sequence
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = REG_READ_FAIL_LIMIT;
    cfg_data                = '0;
    evt_bus.valid           = 1'b0;
    evt_bus.action          = ACT_READ_FAIL;
    evt_bus.now_ms          = '0;
    evt_bus.sample_ms       = '0;
    evt_bus.pressure_ok     = 1'b0;
    evt_bus.raw_altitude_mm = '0;
    mismatches   = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 1'b0;
    ms_clock     = '0;
    trend_mm     = 32'sd250000;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_limits_and_extremes();
    test_random_phases();
    test_report_backpressure();
    test_counter_saturation();

    drain_reports();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
